FILE: rtl/core/tcc_pkg.sv
// Shared types for the triangle circumcenter pipeline.
// Holds the result status code; no dependencies.
package tcc_pkg;

    // Result status of one triangle.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

endpackage

FILE: rtl/core/triangle_circumcenter_top.sv
// Triangle circumcenter, fixed point; uses tcc_pkg and tcc_divider.
// Data pass through stages A to F, the divider stages and the output register to reach the result.
// Throughput: one triangle per cycle while the skid register is empty; depth is set by the one-bit-per-stage dividers.
// A skid register behind the output register holds one result under backpressure; while it is full the pipeline stalls.
// Reset is synchronous, active low, and clears every valid bit, including the output and
// skid flags; data registers are not reset.
module triangle_circumcenter_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COORD_WIDTH-1:0]     i_ax,
    input  logic signed [COORD_WIDTH-1:0]     i_ay,
    input  logic signed [COORD_WIDTH-1:0]     i_bx,
    input  logic signed [COORD_WIDTH-1:0]     i_by_coord,
    input  logic signed [COORD_WIDTH-1:0]     i_cx,
    input  logic signed [COORD_WIDTH-1:0]     i_cy,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [FRAC_BITS+31:0]      o_center_x,
    output logic signed [FRAC_BITS+31:0]      o_center_y,
    output tcc_pkg::t_status                  o_status
);

    import tcc_pkg::*;

    localparam int CW        = COORD_WIDTH;
    localparam int OUT_WIDTH = 32 + FRAC_BITS;
    localparam int DIFW      = CW + 1;
    localparam int PW        = 2 * CW + 2;
    localparam int HALF      = CW + 1;
    localparam int NBW       = 2 * HALF;
    localparam int PPW       = 2 * CW + 3;
    localparam int DDW       = 2 * CW + 4;
    localparam int NUMW      = 3 * CW + 4;
    localparam int NW        = 3 * CW + 4;
    localparam int DW        = 2 * CW + 4;
    localparam int QB        = ((OUT_WIDTH > CW) ? OUT_WIDTH : CW) + 1;
    localparam int VW        = QB + 2;
    localparam int XSW       = CW + 2;
    localparam int YSW       = CW + 1;

    localparam logic signed [VW-1:0] VHI =
        $signed({{(VW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}});
    localparam logic signed [VW-1:0] VLO = -VHI - VW'(1);
    localparam logic [OUT_WIDTH-1:0] OHI = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] OLO = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    // Pipeline advances whenever the skid register is empty.
    logic r_sv;
    logic w_adv;
    assign w_adv   = !r_sv;
    assign o_ready = w_adv;

    // Stage A: vertices relative to the first vertex.
    logic                   r_a_v;
    logic signed [DIFW-1:0] r_a_bx, r_a_by, r_a_cx, r_a_cy;
    logic signed [CW-1:0]   r_a_ax, r_a_ay;
    logic signed [DIFW-1:0] n_bx, n_by, n_cx, n_cy;

    assign n_bx = $signed({i_bx[CW-1], i_bx}) - $signed({i_ax[CW-1], i_ax});
    assign n_by = $signed({i_by_coord[CW-1], i_by_coord}) - $signed({i_ay[CW-1], i_ay});
    assign n_cx = $signed({i_cx[CW-1], i_cx}) - $signed({i_ax[CW-1], i_ax});
    assign n_cy = $signed({i_cy[CW-1], i_cy}) - $signed({i_ay[CW-1], i_ay});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_bx <= n_bx;
            r_a_by <= n_by;
            r_a_cx <= n_cx;
            r_a_cy <= n_cy;
            r_a_ax <= i_ax;
            r_a_ay <= i_ay;
        end
    end

    // Stage B: squares and cross products.
    logic                   r_b_v;
    logic signed [PW-1:0]   r_b_bxbx, r_b_byby, r_b_cxcx, r_b_cycy, r_b_bxcy, r_b_bycx;
    logic signed [DIFW-1:0] r_b_bx, r_b_by, r_b_cx, r_b_cy;
    logic signed [CW-1:0]   r_b_ax, r_b_ay;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_bxbx <= PW'(r_a_bx * r_a_bx);
            r_b_byby <= PW'(r_a_by * r_a_by);
            r_b_cxcx <= PW'(r_a_cx * r_a_cx);
            r_b_cycy <= PW'(r_a_cy * r_a_cy);
            r_b_bxcy <= PW'(r_a_bx * r_a_cy);
            r_b_bycx <= PW'(r_a_by * r_a_cx);
            r_b_bx   <= r_a_bx;
            r_b_by   <= r_a_by;
            r_b_cx   <= r_a_cx;
            r_b_cy   <= r_a_cy;
            r_b_ax   <= r_a_ax;
            r_b_ay   <= r_a_ay;
        end
    end

    // Stage C: squared norms and the doubled determinant.
    logic                   r_c_v;
    logic [NBW-1:0]         r_c_nb, r_c_nc;
    logic signed [DDW-1:0]  r_c_d;
    logic signed [DIFW-1:0] r_c_bx, r_c_by, r_c_cx, r_c_cy;
    logic signed [CW-1:0]   r_c_ax, r_c_ay;
    logic signed [DDW-1:0]  n_det;

    assign n_det = DDW'(r_b_bxcy) - DDW'(r_b_bycx);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_nb <= NBW'($unsigned(r_b_bxbx)) + NBW'($unsigned(r_b_byby));
            r_c_nc <= NBW'($unsigned(r_b_cxcx)) + NBW'($unsigned(r_b_cycy));
            r_c_d  <= n_det <<< 1;
            r_c_bx <= r_b_bx;
            r_c_by <= r_b_by;
            r_c_cx <= r_b_cx;
            r_c_cy <= r_b_cy;
            r_c_ax <= r_b_ax;
            r_c_ay <= r_b_ay;
        end
    end

    // Stage D: partial products of the norms, split in halves, with the offsets.
    logic                  r_d_v;
    logic signed [PPW-1:0] r_d_nbl_cy, r_d_nbh_cy, r_d_ncl_by, r_d_nch_by;
    logic signed [PPW-1:0] r_d_ncl_bx, r_d_nch_bx, r_d_nbl_cx, r_d_nbh_cx;
    logic signed [DDW-1:0] r_d_d;
    logic signed [CW-1:0]  r_d_ax, r_d_ay;
    logic signed [HALF:0]  n_nbl, n_nbh, n_ncl, n_nch;

    assign n_nbl = $signed({1'b0, r_c_nb[HALF-1:0]});
    assign n_nbh = $signed({1'b0, r_c_nb[NBW-1:HALF]});
    assign n_ncl = $signed({1'b0, r_c_nc[HALF-1:0]});
    assign n_nch = $signed({1'b0, r_c_nc[NBW-1:HALF]});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_nbl_cy <= PPW'(n_nbl * r_c_cy);
            r_d_nbh_cy <= PPW'(n_nbh * r_c_cy);
            r_d_ncl_by <= PPW'(n_ncl * r_c_by);
            r_d_nch_by <= PPW'(n_nch * r_c_by);
            r_d_ncl_bx <= PPW'(n_ncl * r_c_bx);
            r_d_nch_bx <= PPW'(n_nch * r_c_bx);
            r_d_nbl_cx <= PPW'(n_nbl * r_c_cx);
            r_d_nbh_cx <= PPW'(n_nbh * r_c_cx);
            r_d_d      <= r_c_d;
            r_d_ax     <= r_c_ax;
            r_d_ay     <= r_c_ay;
        end
    end

    // Stage E: assemble the x and y numerators.
    logic                   r_e_v;
    logic signed [NUMW-1:0] r_e_numx, r_e_numy;
    logic signed [DDW-1:0]  r_e_d;
    logic signed [CW-1:0]   r_e_ax, r_e_ay;
    logic signed [NUMW-1:0] n_nbcy, n_ncby, n_ncbx, n_nbcx;

    assign n_nbcy = (NUMW'(r_d_nbh_cy) <<< HALF) + NUMW'(r_d_nbl_cy);
    assign n_ncby = (NUMW'(r_d_nch_by) <<< HALF) + NUMW'(r_d_ncl_by);
    assign n_ncbx = (NUMW'(r_d_nch_bx) <<< HALF) + NUMW'(r_d_ncl_bx);
    assign n_nbcx = (NUMW'(r_d_nbh_cx) <<< HALF) + NUMW'(r_d_nbl_cx);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_numx <= n_nbcy - n_ncby;
            r_e_numy <= n_ncbx - n_nbcx;
            r_e_d    <= r_d_d;
            r_e_ax   <= r_d_ax;
            r_e_ay   <= r_d_ay;
        end
    end

    // Stage F: magnitudes, rounding bias and quotient signs.
    logic            r_f_v;
    logic [NW-1:0]   r_f_nx, r_f_ny;
    logic [DW-1:0]   r_f_den;
    logic [XSW-1:0]  r_f_xside;
    logic [YSW-1:0]  r_f_yside;
    logic [NUMW-1:0] n_numx_mag, n_numy_mag;
    logic [DDW-1:0]  n_d_mag;

    assign n_numx_mag = r_e_numx[NUMW-1] ? $unsigned(-r_e_numx) : $unsigned(r_e_numx);
    assign n_numy_mag = r_e_numy[NUMW-1] ? $unsigned(-r_e_numy) : $unsigned(r_e_numy);
    assign n_d_mag    = r_e_d[DDW-1] ? $unsigned(-r_e_d) : $unsigned(r_e_d);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_nx    <= {n_numx_mag[NUMW-2:0], 1'b0} + NW'(n_d_mag);
            r_f_ny    <= {n_numy_mag[NUMW-2:0], 1'b0} + NW'(n_d_mag);
            r_f_den   <= {n_d_mag[DDW-2:0], 1'b0};
            r_f_xside <= {(r_e_d == '0), r_e_numx[NUMW-1] ^ r_e_d[DDW-1], r_e_ax};
            r_f_yside <= {r_e_numy[NUMW-1] ^ r_e_d[DDW-1], r_e_ay};
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (w_adv) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
        end
    end

    // Two divider lanes, one per coordinate.
    logic           w_xv, w_yv, w_xover, w_yover;
    logic [QB-1:0]  w_xq, w_yq;
    logic [XSW-1:0] w_xside;
    logic [YSW-1:0] w_yside;

    tcc_divider #(.NW(NW), .DW(DW), .QB(QB), .SW(XSW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_f_v),
        .i_num   (r_f_nx),
        .i_den   (r_f_den),
        .i_side  (r_f_xside),
        .o_valid (w_xv),
        .o_quot  (w_xq),
        .o_over  (w_xover),
        .o_side  (w_xside)
    );

    tcc_divider #(.NW(NW), .DW(DW), .QB(QB), .SW(YSW)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_f_v),
        .i_num   (r_f_ny),
        .i_den   (r_f_den),
        .i_side  (r_f_yside),
        .o_valid (w_yv),
        .o_quot  (w_yq),
        .o_over  (w_yover),
        .o_side  (w_yside)
    );

    // Apply the sign, add the first vertex back and clamp; the top bit flags saturation.
    function automatic logic [OUT_WIDTH:0] f_finish(
        input logic [QB-1:0]        q,
        input logic                 over,
        input logic                 neg,
        input logic signed [CW-1:0] off
    );
        logic signed [VW-1:0] v;
        v = VW'($signed({1'b0, q}));
        if (neg) begin
            v = -v;
        end
        v = v + VW'(off);
        if (over) begin
            return {1'b1, (neg ? OLO : OHI)};
        end else if (v > VHI) begin
            return {1'b1, OHI};
        end else if (v < VLO) begin
            return {1'b1, OLO};
        end else begin
            return {1'b0, v[OUT_WIDTH-1:0]};
        end
    endfunction

    logic [OUT_WIDTH:0]   n_fx, n_fy;
    logic                 n_deg;
    logic [OUT_WIDTH-1:0] n_cx_out, n_cy_out;
    t_status              n_status;

    assign n_fx  = f_finish(w_xq, w_xover, w_xside[CW], w_xside[CW-1:0]);
    assign n_fy  = f_finish(w_yq, w_yover, w_yside[CW], w_yside[CW-1:0]);
    assign n_deg = w_xside[CW+1];

    always_comb begin
        if (n_deg) begin
            n_cx_out = '0;
            n_cy_out = '0;
            n_status = ST_DEGEN;
        end else begin
            n_cx_out = n_fx[OUT_WIDTH-1:0];
            n_cy_out = n_fy[OUT_WIDTH-1:0];
            n_status = (n_fx[OUT_WIDTH] || n_fy[OUT_WIDTH]) ? ST_SAT : ST_OK;
        end
    end

    // Output register with a one-entry skid behind it.
    logic                 r_ov;
    logic [OUT_WIDTH-1:0] r_ocx, r_ocy, r_scx, r_scy;
    t_status              r_ost, r_sst;
    logic                 w_out_free;

    assign w_out_free = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_out_free) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end
        end else if (w_xv) begin
            if (w_out_free) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (w_out_free) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_out_free) begin
                r_ocx <= r_scx;
                r_ocy <= r_scy;
                r_ost <= r_sst;
            end
        end else if (w_xv) begin
            if (w_out_free) begin
                r_ocx <= n_cx_out;
                r_ocy <= n_cy_out;
                r_ost <= n_status;
            end else begin
                r_scx <= n_cx_out;
                r_scy <= n_cy_out;
                r_sst <= n_status;
            end
        end
    end

    assign o_valid    = r_ov;
    assign o_center_x = r_ocx;
    assign o_center_y = r_ocy;
    assign o_status   = r_ost;

`ifndef SYNTH
    // Both divider lanes carry the same item.
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xv == w_yv)
        else $error("divider lanes out of step");

    // The skid register only fills behind a held output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds data while output is empty");

    // The skid register fills only when the output was stalled.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !i_ready))
        else $error("skid filled without backpressure");

    // A degenerate triangle reports the origin.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DEGEN) |-> (o_center_x == '0 && o_center_y == '0))
        else $error("degenerate result with nonzero center");
`endif

endmodule

FILE: rtl/core/tcc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband path.
// Stand-alone; used by triangle_circumcenter_top for the x and y quotients.
module tcc_divider #(
    parameter int NW = 100,
    parameter int DW = 68,
    parameter int QB = 49,
    parameter int SW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QB-1:0] o_quot,
    output logic          o_over,
    output logic [SW-1:0] o_side
);

    localparam int NPAD = QB + DW;

    logic          r_v    [0:QB];
    logic [DW-1:0] r_rem  [0:QB];
    logic [DW-1:0] r_den  [0:QB];
    logic [QB-1:0] r_qn   [0:QB];
    logic          r_over [0:QB];
    logic [SW-1:0] r_side [0:QB];

    logic [NPAD-1:0] n_num_ext;
    logic [DW-1:0]   n_num_top;

    // The quotient overflows when the upper dividend bits already reach the divisor.
    assign n_num_ext = NPAD'(i_num);
    assign n_num_top = n_num_ext[NPAD-1:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_num_top;
            r_den[0]  <= i_den;
            r_qn[0]   <= n_num_ext[QB-1:0];
            r_over[0] <= (n_num_top >= i_den);
            r_side[0] <= i_side;
        end
    end

    // Each stage shifts one dividend bit into the remainder and retires one quotient bit.
    for (genvar j = 0; j < QB; j++) begin : g_stage
        logic [DW:0]   n_trial;
        logic [DW:0]   n_diff;
        logic          n_ge;
        logic [DW-1:0] n_rem;

        assign n_trial = {r_rem[j], r_qn[j][QB-1]};
        assign n_diff  = n_trial - {1'b0, r_den[j]};
        assign n_ge    = (n_trial >= {1'b0, r_den[j]});
        assign n_rem   = n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= n_rem;
                r_den[j+1]  <= r_den[j];
                r_qn[j+1]   <= {r_qn[j][QB-2:0], n_ge};
                r_over[j+1] <= r_over[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_quot  = r_qn[QB];
    assign o_over  = r_over[QB];
    assign o_side  = r_side[QB];

endmodule
